// ===== hw/rtl/depth_sorted_display_list_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DEPTH_SORTED_DISPLAY_LIST_DEFINES_SVH
`define DEPTH_SORTED_DISPLAY_LIST_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DSDL_ASSERT_CLK(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define DSDL_ASSERT_ANY(lbl, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dsdl_pkg.sv =====
`default_nettype none
package dsdl_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] status_t;
	typedef logic [1:0] cfg_idx_t;

	localparam cmd_t CMD_INSERT  = 2'd0;
	localparam cmd_t CMD_CLEAR   = 2'd1;
	localparam cmd_t CMD_POP     = 2'd2;
	localparam cmd_t CMD_POP_ALT = 2'd3;

	localparam status_t ST_STORED  = 3'd0;
	localparam status_t ST_CULLED  = 3'd1;
	localparam status_t ST_FULL    = 3'd2;
	localparam status_t ST_POPPED  = 3'd3;
	localparam status_t ST_EMPTY   = 3'd4;
	localparam status_t ST_CLEARED = 3'd5;

	localparam cfg_idx_t CFG_CAMERA_X = 2'd0;
	localparam cfg_idx_t CFG_CAMERA_Y = 2'd1;
	localparam cfg_idx_t CFG_BORDER_X = 2'd2;
	localparam cfg_idx_t CFG_BORDER_Y = 2'd3;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [15:0] aux_z;
		logic        [15:0] hue;
		logic signed [7:0]  brightness;
		logic        [15:0] sprite_ref;
		logic        [15:0] flags;
		logic               shadow;
	} entry_t;

	typedef struct packed {
		status_t status;
		entry_t  ent;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dsdl_if.sv =====
`default_nettype none
interface dsdl_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic signed [15:0] aux_z;
	logic [15:0]        hue;
	logic signed [7:0]  brightness;
	logic [15:0]        sprite_ref;
	logic [15:0]        draw_flags;
	logic               is_shadow;

	modport source (output valid, cmd, pos_x, pos_y, pos_z, aux_z, hue, brightness,
		sprite_ref, draw_flags, is_shadow, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, pos_z, aux_z, hue, brightness,
		sprite_ref, draw_flags, is_shadow, output ready);
endinterface

interface dsdl_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic signed [15:0] out_aux_z;
	logic [15:0]        out_hue;
	logic signed [7:0]  out_brightness;
	logic [15:0]        out_sprite_ref;
	logic [15:0]        out_flags;
	logic               out_shadow;

	modport source (output valid, status, out_x, out_y, out_z, out_aux_z, out_hue,
		out_brightness, out_sprite_ref, out_flags, out_shadow, input ready);
	modport sink (input valid, status, out_x, out_y, out_z, out_aux_z, out_hue,
		out_brightness, out_sprite_ref, out_flags, out_shadow, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dsdl_ram.sv =====
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module dsdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dsdl_cmp.sv =====
`default_nettype none
// Depth order test: true when the new entry belongs before the visited one.
module dsdl_cmp (
	input  wire logic signed [15:0] node_y,
	input  wire logic signed [15:0] node_z,
	input  wire logic               node_shadow,
	input  wire logic signed [15:0] my_y,
	input  wire logic signed [15:0] my_z,
	output logic                    hit
);
	always_comb begin
		hit = !node_shadow && ((node_y > my_y) || ((node_y == my_y) && (node_z > my_z)));
	end
endmodule
`default_nettype wire

// ===== hw/rtl/depth_sorted_display_list.sv =====
// Depth-sorted display list. Commands arrive as items on in_ch: insert an entry, clear
// the table, or pop the head entry; each item yields exactly one result item on out_ch.
// An insert is first culled against the camera window widened by the borders, then
// rejected if the table holds CAPACITY entries, else stored and linked into a singly
// linked list in depth order (shadows at the head, then ascending y, then ascending z,
// equal keys in arrival order). An insert that walks the list compares against one entry
// at a time and then writes a second link unless it lands at the head. The walk visits
// one entry per cycle through the read port of the entry memory, which the depth compare
// unit examines. There is no clearing pass: clear and reset take effect at once, since
// free slots come from a fill count and a stack of recycled slots. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, and the block itself does not enforce this.
`default_nettype none
module depth_sorted_display_list #(
	parameter int CAPACITY = 1024,
	parameter int SCREEN_W = 640,
	parameter int SCREEN_H = 480
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire dsdl_pkg::cfg_idx_t  cfg_index,
	input  wire logic [15:0]         cfg_data,
	dsdl_in_if.sink                  in_ch,
	dsdl_out_if.source               out_ch
);
	import dsdl_pkg::*;

	// Slot index width, and link width: the top bit of a link marks the null link.
	localparam int IW = $clog2(CAPACITY);
	localparam int LW = IW + 1;
	localparam int CW = IW + 1;
	localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	localparam logic signed [19:0] HALF_W = 20'(SCREEN_W / 2);
	localparam logic signed [19:0] HALF_H = 20'(SCREEN_H / 2);
	localparam logic signed [19:0] FULL_W = 20'(SCREEN_W);
	localparam logic signed [19:0] FULL_H = 20'(SCREEN_H);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CULL    = 4'd1;
	localparam logic [3:0] S_ALLOC   = 4'd2;
	localparam logic [3:0] S_WRITE   = 4'd3;
	localparam logic [3:0] S_WALK_RD = 4'd4;
	localparam logic [3:0] S_CMP     = 4'd5;
	localparam logic [3:0] S_LINK2   = 4'd6;
	localparam logic [3:0] S_POP_RD  = 4'd7;
	localparam logic [3:0] S_POP_DAT = 4'd8;
	localparam logic [3:0] S_EMIT    = 4'd9;

	logic [3:0]         state_q;
	logic signed [15:0] cam_x_q;
	logic signed [15:0] cam_y_q;
	logic [9:0]         bord_x_q;
	logic [9:0]         bord_y_q;

	// List and allocation bookkeeping.
	logic [LW-1:0] head_q;
	logic [CW-1:0] fresh_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] count_q;

	// Walk registers and the held item.
	entry_t        it_q;
	logic [IW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [IW-1:0] me_q;
	logic [IW-1:0] lw_addr_q;
	logic [LW-1:0] lw_data_q;
	result_t       res_q;

	// Output register.
	logic    ovalid_q;
	result_t obuf_q;

	logic          in_acc;
	logic          out_load;
	logic [IW-1:0] rd_addr;
	entry_t        ent_rd;
	logic [LW-1:0] nxt_rd;
	logic          nxt_we;
	logic [IW-1:0] nxt_waddr;
	logic [LW-1:0] nxt_wdata;
	logic [IW-1:0] stk_raddr;
	logic [IW-1:0] stk_rd;
	logic          hit;
	logic          culled;
	logic signed [19:0] dx, dy, bx, by;

	function automatic result_t mk_res(status_t s);
		result_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == S_EMIT) && (!ovalid_q || out_ch.ready);

	// While comparing, the memories are already addressed with the next link so the
	// walk advances one entry per cycle.
	assign rd_addr   = (state_q == S_CMP) ? nxt_rd[IW-1:0] : cur_q;
	assign stk_raddr = IW'(sp_q - 1'b1);

	// Cull window test on the held item, exact in 20 bits.
	always_comb begin
		dx = 20'(it_q.x) - 20'(cam_x_q) + HALF_W;
		dy = 20'(it_q.y) - 20'(cam_y_q) + HALF_H;
		bx = 20'(bord_x_q);
		by = 20'(bord_y_q);
		culled = (dx + bx < 0) || (dx > FULL_W + bx) ||
			(dy + by < 0) || (dy > FULL_H + by);
	end

	// Link memory write port: head insert, walk hit or tail append, then second link.
	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = me_q;
		nxt_wdata = head_q;
		unique case (state_q)
			S_WRITE: begin
				nxt_we = head_q[IW] || it_q.shadow;
			end
			S_CMP: begin
				if (hit) begin
					nxt_we    = 1'b1;
					nxt_wdata = {1'b0, cur_q};
				end else if (nxt_rd[IW]) begin
					nxt_we    = 1'b1;
					nxt_waddr = cur_q;
					nxt_wdata = {1'b0, me_q};
				end
			end
			S_LINK2: begin
				nxt_we    = 1'b1;
				nxt_waddr = lw_addr_q;
				nxt_wdata = lw_data_q;
			end
			default: begin
				nxt_we = 1'b0;
			end
		endcase
	end

	dsdl_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_entry_ram (
		.clk   (clk),
		.we    (state_q == S_WRITE),
		.waddr (me_q),
		.wdata (it_q),
		.raddr (rd_addr),
		.rdata (ent_rd)
	);

	dsdl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (rd_addr),
		.rdata (nxt_rd)
	);

	// Stack of slots freed by pops; slots never used since clear come from fresh_q.
	dsdl_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_ram (
		.clk   (clk),
		.we    (state_q == S_POP_DAT),
		.waddr (sp_q[IW-1:0]),
		.wdata (cur_q),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	dsdl_cmp u_cmp (
		.node_y      (ent_rd.y),
		.node_z      (ent_rd.z),
		.node_shadow (ent_rd.shadow),
		.my_y        (it_q.y),
		.my_z        (it_q.z),
		.hit         (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= 16'sd320;
			cam_y_q  <= 16'sd240;
			bord_x_q <= 10'd64;
			bord_y_q <= 10'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAMERA_X: cam_x_q  <= cfg_data;
				CFG_CAMERA_Y: cam_y_q  <= cfg_data;
				CFG_BORDER_X: bord_x_q <= cfg_data[9:0];
				CFG_BORDER_Y: bord_y_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Sequencer and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NULL_LINK;
			fresh_q <= '0;
			sp_q    <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.cmd) inside
							CMD_CLEAR: begin
								head_q  <= NULL_LINK;
								fresh_q <= '0;
								sp_q    <= '0;
								count_q <= '0;
								state_q <= S_EMIT;
							end
							CMD_POP, CMD_POP_ALT: begin
								state_q <= head_q[IW] ? S_EMIT : S_POP_RD;
							end
							default: begin
								state_q <= S_CULL;
							end
						endcase
					end
				end
				S_CULL: begin
					if (culled || (count_q == FULL_COUNT)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - 1'b1;
					end else begin
						fresh_q <= fresh_q + 1'b1;
					end
					count_q <= count_q + 1'b1;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (head_q[IW] || it_q.shadow) begin
						head_q  <= {1'b0, me_q};
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						if (prev_q[IW]) begin
							head_q  <= {1'b0, me_q};
							state_q <= S_EMIT;
						end else begin
							state_q <= S_LINK2;
						end
					end else if (nxt_rd[IW]) begin
						state_q <= S_LINK2;
					end
				end
				S_LINK2: begin
					state_q <= S_EMIT;
				end
				S_POP_RD: begin
					state_q <= S_POP_DAT;
				end
				S_POP_DAT: begin
					head_q  <= nxt_rd;
					sp_q    <= sp_q + 1'b1;
					count_q <= count_q - 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			it_q.x          <= in_ch.pos_x;
			it_q.y          <= in_ch.pos_y;
			it_q.z          <= in_ch.pos_z;
			it_q.aux_z      <= in_ch.aux_z;
			it_q.hue        <= in_ch.hue;
			it_q.brightness <= in_ch.brightness;
			it_q.sprite_ref <= in_ch.sprite_ref;
			it_q.flags      <= in_ch.draw_flags;
			it_q.shadow     <= in_ch.is_shadow;
			cur_q           <= head_q[IW-1:0];
			unique case (in_ch.cmd) inside
				CMD_CLEAR:            res_q <= mk_res(ST_CLEARED);
				CMD_POP, CMD_POP_ALT: res_q <= mk_res(ST_EMPTY);
				default:              res_q <= mk_res(ST_STORED);
			endcase
		end
		unique case (state_q)
			S_CULL: begin
				if (culled) begin
					res_q <= mk_res(ST_CULLED);
				end else if (count_q == FULL_COUNT) begin
					res_q <= mk_res(ST_FULL);
				end
			end
			S_ALLOC: begin
				me_q <= (sp_q != '0) ? stk_rd : fresh_q[IW-1:0];
			end
			S_WRITE: begin
				cur_q  <= head_q[IW-1:0];
				prev_q <= NULL_LINK;
			end
			S_CMP: begin
				if (hit) begin
					lw_addr_q <= prev_q[IW-1:0];
					lw_data_q <= {1'b0, me_q};
				end else if (nxt_rd[IW]) begin
					lw_addr_q <= me_q;
					lw_data_q <= NULL_LINK;
				end else begin
					prev_q <= {1'b0, cur_q};
					cur_q  <= nxt_rd[IW-1:0];
				end
			end
			S_POP_DAT: begin
				res_q.status <= ST_POPPED;
				res_q.ent    <= ent_rd;
			end
			default: ;
		endcase
		if (out_load) begin
			obuf_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign out_ch.valid          = ovalid_q;
	assign out_ch.status         = obuf_q.status;
	assign out_ch.out_x          = obuf_q.ent.x;
	assign out_ch.out_y          = obuf_q.ent.y;
	assign out_ch.out_z          = obuf_q.ent.z;
	assign out_ch.out_aux_z      = obuf_q.ent.aux_z;
	assign out_ch.out_hue        = obuf_q.ent.hue;
	assign out_ch.out_brightness = obuf_q.ent.brightness;
	assign out_ch.out_sprite_ref = obuf_q.ent.sprite_ref;
	assign out_ch.out_flags      = obuf_q.ent.flags;
	assign out_ch.out_shadow     = obuf_q.ent.shadow;
endmodule
`default_nettype wire

// ===== hw/rtl/dsdl_checker.sv =====
`default_nettype none
`include "depth_sorted_display_list_defines.svh"
module dsdl_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [2:0]         status,
	input wire logic signed [15:0] out_x,
	input wire logic signed [15:0] out_y,
	input wire logic signed [15:0] out_z,
	input wire logic signed [15:0] out_aux_z,
	input wire logic [15:0]        out_hue,
	input wire logic signed [7:0]  out_brightness,
	input wire logic [15:0]        out_sprite_ref,
	input wire logic [15:0]        out_flags,
	input wire logic               out_shadow
);
	import dsdl_pkg::*;

	// A result waiting to be taken stays offered.
	`DSDL_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
	// Every item moves the block out of idle, so ready drops after an accept.
	`DSDL_ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready held")
	// Only a pop carries entry fields.
	`DSDL_ASSERT_CLK(a_zero_payload, out_valid && status != ST_POPPED |-> out_x == 16'sd0 &&
		out_y == 16'sd0 && out_z == 16'sd0 && out_aux_z == 16'sd0 && out_hue == 16'd0 &&
		out_brightness == 8'sd0 && out_sprite_ref == 16'd0 && out_flags == 16'd0 &&
		!out_shadow, "payload on non-pop result")
	// Nothing is offered while reset is held.
	`DSDL_ASSERT_ANY(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")
endmodule

bind depth_sorted_display_list dsdl_checker u_dsdl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.status         (out_ch.status),
	.out_x          (out_ch.out_x),
	.out_y          (out_ch.out_y),
	.out_z          (out_ch.out_z),
	.out_aux_z      (out_ch.out_aux_z),
	.out_hue        (out_ch.out_hue),
	.out_brightness (out_ch.out_brightness),
	.out_sprite_ref (out_ch.out_sprite_ref),
	.out_flags      (out_ch.out_flags),
	.out_shadow     (out_ch.out_shadow)
);
`default_nettype wire
